@@ sv/tcphop_pkg.sv @@
// ============================================================================
// tcphop_pkg
// Shared types and constants for the TCP header and option parser.
// ============================================================================
`default_nettype none

package tcphop_pkg;

    localparam int unsigned OUT_DATA_W = 176;

    localparam logic [5:0] FIXED_HDR_LEN = 6'd20;

    localparam logic [7:0] OPT_EOL = 8'd0;
    localparam logic [7:0] OPT_NOP = 8'd1;

    typedef enum logic [1:0] {
        REC_HEADER = 2'd0,
        REC_OPTION = 2'd1,
        REC_ERROR  = 2'd2
    } t_rec_kind;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_SHORT     = 2'd1,
        ERR_EXCEEDS   = 2'd2,
        ERR_BAD_OPT   = 2'd3
    } t_err_code;

    // option walk phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_HDR  = 4'b0010,
        PH_KIND = 4'b0100,
        PH_LEN  = 4'b1000
    } t_phase;

    typedef struct packed {
        t_rec_kind   rec_kind;
        t_err_code   err_code;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] payload_length;
        logic [31:0] sequence_number;
        logic [31:0] ack_number;
        logic [15:0] window_size;
        logic [15:0] urgent_pointer;
        logic [7:0]  tcp_flags;
        logic [7:0]  option_kind;
        logic [7:0]  option_length;
    } t_rec;

    // fixed data length of known option kinds; others skip length minus two
    function automatic logic [7:0] opt_data_len(input logic [7:0] kind,
                                                input logic [7:0] len);
        logic [7:0] r;
        case (kind)
            8'd2, 8'd28:                      r = 8'd2;
            8'd3:                             r = 8'd1;
            8'd6, 8'd7, 8'd11, 8'd12, 8'd13:  r = 8'd4;
            8'd8:                             r = 8'd8;
            8'd19:                            r = 8'd16;
            8'd0, 8'd1, 8'd4:                 r = 8'd0;
            default:                          r = len - 8'd2;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/tcp_header_option_parser.sv @@
// ============================================================================
// tcp_header_option_parser
// TCP header capture and option walk, one header byte per transaction.
// ============================================================================
//
//  channel   dir  tdata                              tuser
//  s_axis    in   data_byte, segment_length          first_byte
//  m_axis    out  error_code .. option_length (176b) record_kind
//
//  One byte is accepted every cycle unless s_axis stalls; each byte updates
//  state and forms its result combinationally into the result register.
//  A result is held in the skid stage while the result register stays full.
//  Result register plus skid stage: s_axis stalls only when both are full.
//  Reset (i_rst_n low, synchronous) empties the output and idles the walk.
// ============================================================================
`default_nettype none

module tcp_header_option_parser (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // [7:0] data_byte, [23:8] segment_length
    input  wire logic [23:0]   i_s_axis_tdata,
    // [0] first_byte
    input  wire logic          i_s_axis_tuser,
    output logic               o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    // [1:0] error_code, [17:2] source_port, [33:18] dest_port,
    // [49:34] payload_length, [81:50] sequence_number, [113:82] ack_number,
    // [129:114] window_size, [145:130] urgent_pointer, [153:146] tcp_flags,
    // [161:154] option_kind, [169:162] option_length, [175:170] zero
    output logic [tcphop_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // [1:0] record_kind
    output logic [1:0]         o_m_axis_tuser
);

    logic             accept;
    logic             res_valid;
    tcphop_pkg::t_rec res;
    tcphop_pkg::t_rec out_rec;

    assign accept = i_s_axis_tvalid & o_s_axis_tready;

    tcphop_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_data_byte      (i_s_axis_tdata[7:0]),
        .i_first_byte     (i_s_axis_tuser),
        .i_segment_length (i_s_axis_tdata[23:8]),
        .o_res            (res),
        .o_res_valid      (res_valid)
    );

    tcphop_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept & res_valid),
        .i_rec       (res),
        .o_ready     (o_s_axis_tready),
        .o_valid     (o_m_axis_tvalid),
        .i_pop_ready (i_m_axis_tready),
        .o_rec       (out_rec)
    );

    assign o_m_axis_tuser = out_rec.rec_kind;
    assign o_m_axis_tdata = {6'd0,
                             out_rec.option_length,
                             out_rec.option_kind,
                             out_rec.tcp_flags,
                             out_rec.urgent_pointer,
                             out_rec.window_size,
                             out_rec.ack_number,
                             out_rec.sequence_number,
                             out_rec.payload_length,
                             out_rec.dest_port,
                             out_rec.source_port,
                             out_rec.err_code};

endmodule

`default_nettype wire

@@ sv/tcphop_core.sv @@
// ============================================================================
// tcphop_core
// Per-byte header capture and option walk; state registers plus next-state
// and result logic for one accepted byte.
// ============================================================================
`default_nettype none

module tcphop_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_first_byte,
    input  wire logic [15:0]       i_segment_length,
    output tcphop_pkg::t_rec       o_res,
    output logic                   o_res_valid
);

    logic [5:0]          r_byte_pos,  n_byte_pos;
    logic [5:0]          r_hdr_bytes, n_hdr_bytes;
    logic [15:0]         r_seg_len,   n_seg_len;
    logic [15:0]         r_src,       n_src;
    logic [15:0]         r_dst,       n_dst;
    logic [31:0]         r_seq,       n_seq;
    logic [31:0]         r_ack,       n_ack;
    logic [15:0]         r_win,       n_win;
    logic [15:0]         r_urg,       n_urg;
    logic [7:0]          r_flags,     n_flags;
    tcphop_pkg::t_phase  r_phase,     n_phase;
    logic [7:0]          r_pend,      n_pend;
    logic [5:0]          r_skip,      n_skip;
    logic [5:0]          r_obl,       n_obl;

    always_comb begin
        logic [7:0]  b;
        logic [5:0]  p;
        logic [7:0]  dl;
        logic [15:0] pay;

        b = i_data_byte;
        n_byte_pos  = r_byte_pos;
        n_hdr_bytes = r_hdr_bytes;
        n_seg_len   = r_seg_len;
        n_src       = r_src;
        n_dst       = r_dst;
        n_seq       = r_seq;
        n_ack       = r_ack;
        n_win       = r_win;
        n_urg       = r_urg;
        n_flags     = r_flags;
        n_phase     = r_phase;
        n_pend      = r_pend;
        n_skip      = r_skip;
        n_obl       = r_obl;
        o_res       = '0;
        o_res_valid = 1'b0;
        dl          = '0;
        pay         = '0;

        // a first byte abandons whatever segment was in progress
        if (i_first_byte) begin
            n_seg_len   = i_segment_length;
            n_byte_pos  = '0;
            n_hdr_bytes = '0;
            n_skip      = '0;
            n_obl       = '0;
            n_pend      = '0;
            n_phase     = tcphop_pkg::PH_HDR;
        end

        p = n_byte_pos;

        case (n_phase)
            tcphop_pkg::PH_HDR: begin
                n_byte_pos = p + 6'd1;
                if (p < 6'd2) begin
                    n_src = {n_src[7:0], b};
                end else if (p < 6'd4) begin
                    n_dst = {n_dst[7:0], b};
                end else if (p < 6'd8) begin
                    n_seq = {n_seq[23:0], b};
                end else if (p < 6'd12) begin
                    n_ack = {n_ack[23:0], b};
                end else if (p == 6'd12) begin
                    n_hdr_bytes = {b[7:4], 2'b00};
                    if (n_hdr_bytes < tcphop_pkg::FIXED_HDR_LEN) begin
                        n_phase = tcphop_pkg::PH_IDLE;
                        o_res_valid = 1'b1;
                        o_res.rec_kind = tcphop_pkg::REC_ERROR;
                        o_res.err_code = tcphop_pkg::ERR_SHORT;
                        o_res.payload_length = n_seg_len - {10'd0, n_hdr_bytes};
                    end
                end else if (p == 6'd13) begin
                    n_flags = b;
                end else if (p < 6'd16) begin
                    n_win = {n_win[7:0], b};
                end else if (p >= 6'd18) begin
                    n_urg = {n_urg[7:0], b};
                    if (p == 6'd19) begin
                        pay = n_seg_len - {10'd0, n_hdr_bytes};
                        o_res_valid = 1'b1;
                        o_res.source_port     = n_src;
                        o_res.dest_port       = n_dst;
                        o_res.payload_length  = pay;
                        o_res.sequence_number = n_seq;
                        o_res.ack_number      = n_ack;
                        o_res.window_size     = n_win;
                        o_res.urgent_pointer  = n_urg;
                        o_res.tcp_flags       = n_flags;
                        if ({10'd0, n_hdr_bytes} > n_seg_len) begin
                            n_phase = tcphop_pkg::PH_IDLE;
                            o_res.rec_kind = tcphop_pkg::REC_ERROR;
                            o_res.err_code = tcphop_pkg::ERR_EXCEEDS;
                        end else begin
                            n_obl  = n_hdr_bytes - tcphop_pkg::FIXED_HDR_LEN;
                            n_skip = '0;
                            n_phase = (n_obl != 6'd0) ? tcphop_pkg::PH_KIND
                                                      : tcphop_pkg::PH_IDLE;
                            o_res.rec_kind = tcphop_pkg::REC_HEADER;
                            o_res.err_code = tcphop_pkg::ERR_NONE;
                        end
                    end
                end
            end
            tcphop_pkg::PH_KIND: begin
                if (n_skip != 6'd0) begin
                    n_skip = n_skip - 6'd1;
                    n_obl  = n_obl - 6'd1;
                    if (n_obl == 6'd0) begin
                        n_phase = tcphop_pkg::PH_IDLE;
                    end
                end else if (b == tcphop_pkg::OPT_EOL) begin
                    n_phase = tcphop_pkg::PH_IDLE;
                    o_res_valid = 1'b1;
                    o_res.rec_kind = tcphop_pkg::REC_OPTION;
                    o_res.option_kind = b;
                    o_res.option_length = 8'd1;
                end else if (b == tcphop_pkg::OPT_NOP) begin
                    n_obl = n_obl - 6'd1;
                    if (n_obl == 6'd0) begin
                        n_phase = tcphop_pkg::PH_IDLE;
                    end
                    o_res_valid = 1'b1;
                    o_res.rec_kind = tcphop_pkg::REC_OPTION;
                    o_res.option_kind = b;
                    o_res.option_length = 8'd1;
                end else if (n_obl < 6'd2) begin
                    // kind with no room left for its length byte
                    n_phase = tcphop_pkg::PH_IDLE;
                    o_res_valid = 1'b1;
                    o_res.rec_kind = tcphop_pkg::REC_ERROR;
                    o_res.err_code = tcphop_pkg::ERR_BAD_OPT;
                    o_res.option_kind = b;
                end else begin
                    n_pend  = b;
                    n_obl   = n_obl - 6'd1;
                    n_phase = tcphop_pkg::PH_LEN;
                end
            end
            tcphop_pkg::PH_LEN: begin
                o_res_valid = 1'b1;
                o_res.option_kind = n_pend;
                o_res.option_length = b;
                if (b < 8'd2 || b > ({2'd0, n_obl} + 8'd1)) begin
                    n_phase = tcphop_pkg::PH_IDLE;
                    o_res.rec_kind = tcphop_pkg::REC_ERROR;
                    o_res.err_code = tcphop_pkg::ERR_BAD_OPT;
                end else begin
                    n_obl = n_obl - 6'd1;
                    dl = tcphop_pkg::opt_data_len(n_pend, b);
                    o_res.rec_kind = tcphop_pkg::REC_OPTION;
                    if (dl > {2'd0, n_obl}) begin
                        // fixed skip past the header end: stop without error
                        n_phase = tcphop_pkg::PH_IDLE;
                    end else begin
                        n_skip  = dl[5:0];
                        n_phase = (n_obl == 6'd0) ? tcphop_pkg::PH_IDLE
                                                  : tcphop_pkg::PH_KIND;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos  <= '0;
            r_hdr_bytes <= '0;
            r_seg_len   <= '0;
            r_src       <= '0;
            r_dst       <= '0;
            r_seq       <= '0;
            r_ack       <= '0;
            r_win       <= '0;
            r_urg       <= '0;
            r_flags     <= '0;
            r_phase     <= tcphop_pkg::PH_IDLE;
            r_pend      <= '0;
            r_skip      <= '0;
            r_obl       <= '0;
        end else if (i_accept) begin
            r_byte_pos  <= n_byte_pos;
            r_hdr_bytes <= n_hdr_bytes;
            r_seg_len   <= n_seg_len;
            r_src       <= n_src;
            r_dst       <= n_dst;
            r_seq       <= n_seq;
            r_ack       <= n_ack;
            r_win       <= n_win;
            r_urg       <= n_urg;
            r_flags     <= n_flags;
            r_phase     <= n_phase;
            r_pend      <= n_pend;
            r_skip      <= n_skip;
            r_obl       <= n_obl;
        end
    end

`ifndef NO_ASSERTIONS
    a_first_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_first_byte
        |=> r_phase == tcphop_pkg::PH_HDR && r_byte_pos == 6'd1)
        else $error("first byte did not restart header capture");

    a_walk_has_options: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == tcphop_pkg::PH_KIND || r_phase == tcphop_pkg::PH_LEN)
        |-> r_hdr_bytes > tcphop_pkg::FIXED_HDR_LEN && r_obl != 6'd0)
        else $error("option walk active without option bytes");

    a_hdr_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == tcphop_pkg::PH_HDR |-> r_byte_pos < 6'd20)
        else $error("header byte position past fixed header");
`endif

endmodule

`default_nettype wire

@@ sv/tcphop_outbuf.sv @@
// ============================================================================
// tcphop_outbuf
// Result register with a skid stage; upstream ready comes from a flop.
// ============================================================================
`default_nettype none

module tcphop_outbuf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  tcphop_pkg::t_rec       i_rec,
    output logic                   o_ready,
    output logic                   o_valid,
    input  wire logic              i_pop_ready,
    output tcphop_pkg::t_rec       o_rec
);

    tcphop_pkg::t_rec r_out, r_skid;
    logic             r_out_v, r_skid_v;
    logic             pop;

    assign pop     = r_out_v & i_pop_ready;
    assign o_ready = ~r_skid_v;
    assign o_valid = r_out_v;
    assign o_rec   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (pop) begin
            if (r_skid_v) begin
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= i_push;
            end
        end else if (i_push) begin
            if (!r_out_v) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= r_skid_v ? r_skid : i_rec;
        end else if (i_push) begin
            if (!r_out_v) begin
                r_out <= i_rec;
            end else begin
                r_skid <= i_rec;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held with empty output register");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_v)
        else $error("result pushed while skid full");

    a_skid_drains_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v && pop |=> r_out_v && !r_skid_v && r_out == $past(r_skid))
        else $error("skid entry not moved to output");
`endif

endmodule

`default_nettype wire
